// ----- rtl/i2cras_pkg.sv -----
// Shared types and constants for the I2C register access sequencer.
// Used by i2cras_buf and i2c_register_access_sequencer_top; no dependencies.
package i2cras_pkg;

  // Buffer geometry.
  localparam int MAX_LEN = 16;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);

  // Operation codes of an input transaction.
  localparam logic [2:0] OP_START_READ  = 3'd0;
  localparam logic [2:0] OP_START_WRITE = 3'd1;
  localparam logic [2:0] OP_LOAD        = 3'd2;
  localparam logic [2:0] OP_STEP        = 3'd3;
  localparam logic [2:0] OP_ABORT       = 3'd4;

  // Result kinds.
  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_RX   = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;

  // Read/write bit appended to the device address.
  localparam logic READ_BIT  = 1'b1;
  localparam logic WRITE_BIT = 1'b0;

  // Bus sequencing phase.
  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_SADDR  = 4'd1,
    PH_SREG   = 4'd2,
    PH_WDATA  = 4'd3,
    PH_WSTOP  = 4'd4,
    PH_RSTART = 4'd5,
    PH_RADDR  = 4'd6,
    PH_RONE   = 4'd7,
    PH_RFIRST = 4'd8,
    PH_RMID   = 4'd9,
    PH_RLAST  = 4'd10,
    PH_RSTOP  = 4'd11
  } phase_t;

  // Control sequencer state.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_EXEC  = 2'd1,
    ST_RDREQ = 2'd2,
    ST_RDOUT = 2'd3
  } ctl_state_t;

  // Input transaction payload.
  typedef struct packed {
    logic [2:0] operation;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [4:0] byte_count;
    logic [7:0] data_byte;
    logic [3:0] load_index;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [1:0] kind;
    logic       send_start;
    logic       send_stop;
    logic       ack_next;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [7:0] rx_byte;
    logic [3:0] rx_index;
    logic       last;
    logic       busy_res;
  } out_item_t;

  // Access request to the data buffer.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } buf_req_t;

endpackage

// ----- rtl/i2cras_buf.sv -----
// Data buffer of the sequencer: one write port, one registered read port.
// Depends on i2cras_pkg for the depth and the request struct.
module i2cras_buf (
  input  logic                clk,
  input  i2cras_pkg::buf_req_t req,
  output logic [7:0]          rdata
);
  import i2cras_pkg::*;

  logic [7:0] mem [MAX_LEN];
  logic [7:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/i2c_register_access_sequencer_top.sv -----
// I2C master register read/write sequencer, top level.
// An accepted transaction is registered, and its result is loaded into the output
// register once the output is free; no new transaction is taken until then. After
// the final read stop, each received byte is read from the buffer and presented in turn.
// Reset (synchronous, active low) clears phase, control and output valid; the
// data buffer is not cleared. Depends on i2cras_pkg and i2cras_buf.
module i2c_register_access_sequencer_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  i2cras_pkg::in_item_t in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output i2cras_pkg::out_item_t out_data
);
  import i2cras_pkg::*;

  ctl_state_t       state_r, state_nxt;
  phase_t           phase_r, phase_nxt;
  in_item_t         item_r;
  logic             is_write_r, is_write_nxt;
  logic [6:0]       taddr_r, taddr_nxt;
  logic [7:0]       treg_r, treg_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] bc_r, bc_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  out_item_t        res;
  logic             load_en;
  logic             out_free;
  logic [CNT_W-1:0] len_clamp;
  logic [CNT_W-1:0] bc_inc;
  logic [7:0]       rdata;
  buf_req_t         req;

  i2cras_buf u_buf (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // Handshake side signals.
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Length clamp to 1..MAX_LEN and the byte counter increment.
  always_comb begin
    if (item_r.byte_count == '0) begin
      len_clamp = CNT_W'(1);
    end else if (item_r.byte_count > CNT_W'(MAX_LEN)) begin
      len_clamp = CNT_W'(MAX_LEN);
    end else begin
      len_clamp = item_r.byte_count;
    end
    bc_inc = bc_r + CNT_W'(1);
  end

  // Sequencer: next state, buffer requests and the result.
  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    is_write_nxt = is_write_r;
    taddr_nxt    = taddr_r;
    treg_nxt     = treg_r;
    len_nxt      = len_r;
    bc_nxt       = bc_r;
    rd_idx_nxt   = rd_idx_r;
    load_en      = 1'b0;
    req          = '0;
    res          = '0;
    res.kind     = KIND_NONE;
    res.last     = 1'b1;

    case (state_r)
      ST_IDLE: begin
        // Prefetch the byte a write data phase would send.
        if (in_valid) begin
          state_nxt = ST_EXEC;
          req.re    = 1'b1;
          req.raddr = bc_r[IDX_W-1:0];
        end
      end

      ST_EXEC: begin
        if (out_free) begin
          load_en   = 1'b1;
          state_nxt = ST_IDLE;
          case (item_r.operation)
            OP_START_READ, OP_START_WRITE: begin
              if (phase_r == PH_IDLE) begin
                is_write_nxt   = item_r.operation[0];
                taddr_nxt      = item_r.device_address;
                treg_nxt       = item_r.register_address;
                len_nxt        = len_clamp;
                bc_nxt         = '0;
                phase_nxt      = PH_SADDR;
                res.kind       = KIND_CMD;
                res.send_start = 1'b1;
              end
            end

            OP_LOAD: begin
              if ({1'b0, item_r.load_index} < CNT_W'(MAX_LEN)) begin
                req.we    = 1'b1;
                req.waddr = item_r.load_index[IDX_W-1:0];
                req.wdata = item_r.data_byte;
              end
            end

            OP_ABORT: begin
              phase_nxt = PH_IDLE;
              bc_nxt    = '0;
            end

            OP_STEP: begin
              if (phase_r != PH_IDLE) begin
                res.kind = KIND_CMD;
                case (phase_r)
                  PH_SADDR: begin
                    phase_nxt    = PH_SREG;
                    res.tx_valid = 1'b1;
                    res.tx_byte  = {taddr_r, WRITE_BIT};
                  end
                  PH_SREG: begin
                    phase_nxt    = is_write_r ? PH_WDATA : PH_RSTART;
                    res.tx_valid = 1'b1;
                    res.tx_byte  = treg_r;
                  end
                  PH_WDATA: begin
                    bc_nxt       = bc_inc;
                    phase_nxt    = (bc_inc >= len_r) ? PH_WSTOP : PH_WDATA;
                    res.tx_valid = 1'b1;
                    res.tx_byte  = (bc_r < CNT_W'(MAX_LEN)) ? rdata : 8'h00;
                  end
                  PH_WSTOP: begin
                    phase_nxt     = PH_IDLE;
                    res.send_stop = 1'b1;
                  end
                  PH_RSTART: begin
                    phase_nxt      = PH_RADDR;
                    res.send_start = 1'b1;
                  end
                  PH_RADDR: begin
                    phase_nxt    = (len_r == CNT_W'(1)) ? PH_RONE : PH_RFIRST;
                    res.tx_valid = 1'b1;
                    res.tx_byte  = {taddr_r, READ_BIT};
                  end
                  PH_RONE: begin
                    phase_nxt = PH_RSTOP;
                  end
                  PH_RFIRST: begin
                    phase_nxt    = (len_r == CNT_W'(2)) ? PH_RLAST : PH_RMID;
                    res.ack_next = 1'b1;
                  end
                  PH_RMID: begin
                    req.we       = (bc_r < CNT_W'(MAX_LEN));
                    req.waddr    = bc_r[IDX_W-1:0];
                    req.wdata    = item_r.data_byte;
                    bc_nxt       = bc_inc;
                    phase_nxt    = (({1'b0, bc_inc} + (CNT_W+1)'(2)) >= {1'b0, len_r})
                                   ? PH_RLAST : PH_RMID;
                    res.ack_next = 1'b1;
                  end
                  PH_RLAST: begin
                    req.we    = (bc_r < CNT_W'(MAX_LEN));
                    req.waddr = bc_r[IDX_W-1:0];
                    req.wdata = item_r.data_byte;
                    bc_nxt    = bc_inc;
                    phase_nxt = PH_RSTOP;
                  end
                  PH_RSTOP: begin
                    // Final byte goes in, then the buffer is read out.
                    req.we        = (bc_r < CNT_W'(MAX_LEN));
                    req.waddr     = bc_r[IDX_W-1:0];
                    req.wdata     = item_r.data_byte;
                    bc_nxt        = '0;
                    phase_nxt     = PH_IDLE;
                    res.send_stop = 1'b1;
                    res.last      = 1'b0;
                    rd_idx_nxt    = '0;
                    state_nxt     = ST_RDREQ;
                  end
                  default: begin
                    phase_nxt = PH_IDLE;
                    res.kind  = KIND_NONE;
                  end
                endcase
              end
            end

            default: begin
            end
          endcase
          res.busy_res = (phase_nxt != PH_IDLE);
        end
      end

      ST_RDREQ: begin
        req.re    = 1'b1;
        req.raddr = rd_idx_r[IDX_W-1:0];
        state_nxt = ST_RDOUT;
      end

      ST_RDOUT: begin
        // One received byte per transaction; the last one ends the run.
        if (out_free) begin
          load_en      = 1'b1;
          res.kind     = KIND_RX;
          res.rx_byte  = rdata;
          res.rx_index = rd_idx_r[IDX_W-1:0];
          res.last     = ((rd_idx_r + CNT_W'(1)) == len_r);
          res.busy_res = 1'b0;
          rd_idx_nxt   = rd_idx_r + CNT_W'(1);
          state_nxt    = res.last ? ST_IDLE : ST_RDREQ;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register next value.
  always_comb begin
    out_data_nxt = load_en ? res : out_data_r;
    if (load_en) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_IDLE;
      is_write_r  <= 1'b0;
      taddr_r     <= '0;
      treg_r      <= '0;
      len_r       <= '0;
      bc_r        <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      is_write_r  <= is_write_nxt;
      taddr_r     <= taddr_nxt;
      treg_r      <= treg_nxt;
      len_r       <= len_nxt;
      bc_r        <= bc_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  // A running transfer always has a length in range.
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> (len_r != '0 && len_r <= CNT_W'(MAX_LEN)))
    else $error("transfer length out of range during a transfer");

  // The read-out index never passes the transfer length.
  a_rd_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RDREQ || state_r == ST_RDOUT) |-> (rd_idx_r < len_r))
    else $error("read-out index beyond transfer length");

  // Received bytes are only delivered once the transfer has ended.
  a_rx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (load_en && res.kind == KIND_RX) |-> (phase_r == PH_IDLE && !res.busy_res))
    else $error("received byte delivered while a transfer is running");

endmodule

// ----- bench/i2c_register_access_sequencer_top_tb.sv -----
// Self-checking testbench for i2c_register_access_sequencer_top.
// Random register read and write sequences with noise, checked against a scoreboard
// that tracks the sequencer phase. Depends on i2cras_pkg and the sequencer RTL.
`timescale 1ns / 1ps

module i2c_register_access_sequencer_top_tb;
  import i2cras_pkg::*;

  // Operation codes the block has no meaning for.
  localparam logic [2:0] OP_RESERVED_MIN = 3'd5;
  localparam logic [2:0] OP_RESERVED_MAX = 3'd7;
  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_PRINTED = 100;

  // Scoreboard: tracks the bus phase and predicts every result transaction.
  class bus_sequence_scoreboard;
    phase_t     phase;
    logic       is_write;
    logic [6:0] target_address;
    logic [7:0] target_register;
    logic [4:0] transfer_length;
    logic [4:0] byte_counter;
    logic [7:0] data_buffer [MAX_LEN];
    out_item_t  expected_results [$];
    int         mismatch_count;
    int         results_seen;

    function new();
      phase = PH_IDLE;
      is_write = 1'b0;
      target_address = '0;
      target_register = '0;
      transfer_length = '0;
      byte_counter = '0;
      foreach (data_buffer[i]) data_buffer[i] = '0;
      mismatch_count = 0;
      results_seen = 0;
    endfunction

    function void push_command(logic sta, logic sto, logic ack, logic txv,
                               logic [7:0] txb, logic lst);
      out_item_t r;
      r = '0;
      r.kind = KIND_CMD;
      r.send_start = sta;
      r.send_stop = sto;
      r.ack_next = ack;
      r.tx_valid = txv;
      r.tx_byte = txb;
      r.last = lst;
      r.busy_res = (phase != PH_IDLE);
      expected_results.push_back(r);
    endfunction

    function void push_no_action();
      out_item_t r;
      r = '0;
      r.kind = KIND_NONE;
      r.last = 1'b1;
      r.busy_res = (phase != PH_IDLE);
      expected_results.push_back(r);
    endfunction

    // A byte clocked in from the bus lands at the current count position.
    function void store_received(logic [7:0] rx);
      if (byte_counter < MAX_LEN) data_buffer[byte_counter[IDX_W-1:0]] = rx;
    endfunction

    // One completed bus step: move to the next phase and issue its command.
    function void advance_bus(logic [7:0] rx);
      logic [7:0] tx;
      out_item_t  r;
      case (phase)
        PH_SADDR: begin
          phase = PH_SREG;
          push_command(1'b0, 1'b0, 1'b0, 1'b1, {target_address, WRITE_BIT}, 1'b1);
        end
        PH_SREG: begin
          phase = is_write ? PH_WDATA : PH_RSTART;
          push_command(1'b0, 1'b0, 1'b0, 1'b1, target_register, 1'b1);
        end
        PH_WDATA: begin
          tx = (byte_counter < MAX_LEN) ? data_buffer[byte_counter[IDX_W-1:0]] : 8'h00;
          byte_counter = byte_counter + 1'b1;
          phase = (byte_counter >= transfer_length) ? PH_WSTOP : PH_WDATA;
          push_command(1'b0, 1'b0, 1'b0, 1'b1, tx, 1'b1);
        end
        PH_WSTOP: begin
          phase = PH_IDLE;
          push_command(1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1);
        end
        PH_RSTART: begin
          phase = PH_RADDR;
          push_command(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1);
        end
        PH_RADDR: begin
          phase = (transfer_length == 1) ? PH_RONE : PH_RFIRST;
          push_command(1'b0, 1'b0, 1'b0, 1'b1, {target_address, READ_BIT}, 1'b1);
        end
        PH_RONE: begin
          phase = PH_RSTOP;
          push_command(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1);
        end
        PH_RFIRST: begin
          phase = (transfer_length == 2) ? PH_RLAST : PH_RMID;
          push_command(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1);
        end
        PH_RMID: begin
          store_received(rx);
          byte_counter = byte_counter + 1'b1;
          phase = (byte_counter + 2 >= transfer_length) ? PH_RLAST : PH_RMID;
          push_command(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1);
        end
        PH_RLAST: begin
          // The NACK for the last byte goes out here; the stop waits one step.
          store_received(rx);
          byte_counter = byte_counter + 1'b1;
          phase = PH_RSTOP;
          push_command(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1);
        end
        PH_RSTOP: begin
          // Stop first, then the whole received run with last on the final byte.
          store_received(rx);
          phase = PH_IDLE;
          byte_counter = '0;
          push_command(1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
          for (int i = 0; i < transfer_length && i < MAX_LEN; i++) begin
            r = '0;
            r.kind = KIND_RX;
            r.rx_byte = data_buffer[i];
            r.rx_index = i[3:0];
            r.last = (i + 1 == transfer_length);
            expected_results.push_back(r);
          end
        end
        default: begin
          phase = PH_IDLE;
          push_no_action();
        end
      endcase
    endfunction

    // Called for every accepted input transaction.
    function void note_request(in_item_t req);
      logic [4:0] len;
      case (req.operation)
        OP_START_READ, OP_START_WRITE: begin
          if (phase != PH_IDLE) begin
            push_no_action();
          end else begin
            len = req.byte_count;
            if (len == 0) len = 5'(1);
            else if (len > MAX_LEN) len = 5'(MAX_LEN);
            is_write = (req.operation == OP_START_WRITE);
            target_address = req.device_address;
            target_register = req.register_address;
            transfer_length = len;
            byte_counter = '0;
            phase = PH_SADDR;
            push_command(1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1);
          end
        end
        OP_LOAD: begin
          if (req.load_index < MAX_LEN) data_buffer[req.load_index] = req.data_byte;
          push_no_action();
        end
        OP_ABORT: begin
          phase = PH_IDLE;
          byte_counter = '0;
          push_no_action();
        end
        OP_STEP: begin
          if (phase == PH_IDLE) push_no_action();
          else advance_bus(req.data_byte);
        end
        default: push_no_action();
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) $display("MISMATCH result %0d: %s", results_seen, msg);
    endtask

    task compare_field(string name, int got, int want);
      if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Called for every accepted result transaction.
    task check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
        return;
      end
      want = expected_results.pop_front();
      compare_field("kind", got.kind, want.kind);
      compare_field("send_start", got.send_start, want.send_start);
      compare_field("send_stop", got.send_stop, want.send_stop);
      compare_field("ack_next", got.ack_next, want.ack_next);
      compare_field("tx_valid", got.tx_valid, want.tx_valid);
      compare_field("tx_byte", got.tx_byte, want.tx_byte);
      compare_field("rx_byte", got.rx_byte, want.rx_byte);
      compare_field("rx_index", got.rx_index, want.rx_index);
      compare_field("last", got.last, want.last);
      compare_field("busy_res", got.busy_res, want.busy_res);
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  bus_sequence_scoreboard sb;
  int               sender_idle;
  int               receiver_idle;
  int               hold_left;
  int               work_items;
  int               cycle_count;
  bit [MAX_LEN-1:0] loaded;

  i2c_register_access_sequencer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Clock with a 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Receiver: a requested hold-off first, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall = ($urandom_range(0, 99) < receiver_idle);
    end
  end

  // Every result transaction taken by the receiver is checked.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic in_item_t random_item(logic [2:0] op);
    in_item_t r;
    r.operation = op;
    r.device_address = 7'($urandom_range(0, 127));
    r.register_address = 8'($urandom_range(0, 255));
    r.byte_count = 5'($urandom_range(0, 31));
    r.data_byte = 8'($urandom_range(0, 255));
    r.load_index = 4'($urandom_range(0, 15));
    return r;
  endfunction

  // Offer one transaction after a random gap; returns just after a falling edge.
  task automatic send_item(in_item_t req);
    while ($urandom_range(0, 99) < sender_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = req;
    do @(posedge clk); while (in_stall);
    sb.note_request(req);
    @(negedge clk);
  endtask

  task automatic load_entry(int idx, logic [7:0] value);
    in_item_t req;
    req = random_item(OP_LOAD);
    req.load_index = 4'(idx);
    req.data_byte = value;
    send_item(req);
    loaded[idx] = 1'b1;
    work_items++;
  endtask

  task automatic step_until_idle();
    while (sb.phase != PH_IDLE) begin
      send_item(random_item(OP_STEP));
      work_items++;
    end
  endtask

  task automatic wait_drain();
    while (sb.expected_results.size() != 0) @(negedge clk);
  endtask

  // Extremes of the fields and each corner case, one at a time.
  task automatic run_directed();
    in_item_t req;
    // Idle block: a step, a reserved operation and an abort do nothing.
    send_item(random_item(OP_STEP));
    send_item(random_item(OP_RESERVED_MAX));
    send_item(random_item(OP_ABORT));
    load_entry(0, 8'hFF);
    load_entry(MAX_LEN - 1, 8'h00);
    // Zero length is raised to one; a second start while busy is ignored.
    req = random_item(OP_START_WRITE);
    req.device_address = 7'h7F;
    req.register_address = 8'hFF;
    req.byte_count = 5'd0;
    send_item(req);
    send_item(random_item(OP_START_READ));
    step_until_idle();
    // Single-byte read, with a load and a reserved operation while busy.
    req = random_item(OP_START_READ);
    req.device_address = 7'h00;
    req.register_address = 8'h00;
    req.byte_count = 5'd1;
    send_item(req);
    load_entry(MAX_LEN - 1, 8'h5A);
    send_item(random_item(OP_RESERVED_MIN));
    step_until_idle();
    // Oversized length is clamped; abort partway through without a stop.
    req = random_item(OP_START_WRITE);
    req.byte_count = 5'd31;
    send_item(req);
    send_item(random_item(OP_STEP));
    send_item(random_item(OP_STEP));
    send_item(random_item(OP_ABORT));
  endtask

  // One complete read or write sequence with some noise mixed in.
  task automatic run_transfer();
    in_item_t req;
    int       len_field;
    int       len;
    bit       write;
    write = 1'($urandom_range(0, 1));
    // Mostly short transfers; now and then zero, the full buffer or beyond.
    case ($urandom_range(0, 9))
      0: len_field = $urandom_range(MAX_LEN, 31);
      1: len_field = 0;
      default: len_field = $urandom_range(1, 4);
    endcase
    len = (len_field == 0) ? 1 : ((len_field > MAX_LEN) ? MAX_LEN : len_field);
    // Every byte a write will send must have been loaded at some point.
    if (write) begin
      for (int i = 0; i < len; i++) begin
        if (!loaded[i] || $urandom_range(0, 3) == 0) load_entry(i, 8'($urandom_range(0, 255)));
      end
    end
    req = random_item(write ? OP_START_WRITE : OP_START_READ);
    req.byte_count = 5'(len_field);
    send_item(req);
    work_items++;
    while (sb.phase != PH_IDLE) begin
      case ($urandom_range(0, 79))
        0: send_item(random_item(write ? OP_START_READ : OP_START_WRITE));
        1: load_entry($urandom_range(0, MAX_LEN - 1), 8'($urandom_range(0, 255)));
        2: send_item(random_item(3'($urandom_range(OP_RESERVED_MIN, OP_RESERVED_MAX))));
        3: begin
          send_item(random_item(OP_ABORT));
          work_items++;
        end
        default: begin
          send_item(random_item(OP_STEP));
          work_items++;
        end
      endcase
    end
  endtask

  task automatic run_random(int count);
    int goal;
    goal = work_items + count;
    while (work_items < goal) begin
      // Between sequences, occasionally something the idle block must shrug off.
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: send_item(random_item(OP_STEP));
          1: send_item(random_item(OP_ABORT));
          2: send_item(random_item(3'($urandom_range(OP_RESERVED_MIN, OP_RESERVED_MAX))));
          default: load_entry($urandom_range(0, MAX_LEN - 1), 8'($urandom_range(0, 255)));
        endcase
      end
      run_transfer();
    end
  endtask

  // Main sequence: reset, directed items, then three random phases.
  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    sender_idle = 22;
    receiver_idle = 69;
    hold_left = 0;
    work_items = 0;
    loaded = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    run_random(170);
    // Sender goes quiet until the block has delivered everything.
    in_valid = 1'b0;
    wait_drain();

    sender_idle = 69;
    receiver_idle = 22;
    run_random(170);

    // No idling, but the receiver first holds off long enough to back up the input.
    sender_idle = 0;
    receiver_idle = 0;
    hold_left = 300;
    run_random(170);

    in_valid = 1'b0;
    wait_drain();
    repeat (8) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
